@@ rtl/iloc_instruction_executor_macros.svh @@
// Assertion shorthands, clocked on i_clk and idle during reset.
`ifndef ILOC_INSTRUCTION_EXECUTOR_MACROS_SVH
`define ILOC_INSTRUCTION_EXECUTOR_MACROS_SVH

`define ILOC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define ILOC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) ante |=> cons) else $error(msg);

`endif

@@ rtl/iloc_pkg.sv @@
package iloc_pkg;

    localparam logic [3:0] OP_ADD     = 4'd0;
    localparam logic [3:0] OP_SUB     = 4'd1;
    localparam logic [3:0] OP_MUL     = 4'd2;
    localparam logic [3:0] OP_ADDI    = 4'd3;
    localparam logic [3:0] OP_SUBI    = 4'd4;
    localparam logic [3:0] OP_MULTI   = 4'd5;
    localparam logic [3:0] OP_LSHIFT  = 4'd6;
    localparam logic [3:0] OP_RSHIFT  = 4'd7;
    localparam logic [3:0] OP_LOADI   = 4'd8;
    localparam logic [3:0] OP_LOAD    = 4'd9;
    localparam logic [3:0] OP_LOADAI  = 4'd10;
    localparam logic [3:0] OP_STORE   = 4'd11;
    localparam logic [3:0] OP_STOREAI = 4'd12;
    localparam logic [3:0] OP_OUT_IMM = 4'd13;
    localparam logic [3:0] OP_OUT_AI  = 4'd14;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [5:0]  src_a_reg;
        logic [5:0]  src_b_reg;
        logic [5:0]  dest_reg;
        logic [30:0] imm_value;
    } t_in_beat;

    typedef struct packed {
        logic               has_output;
        logic signed [31:0] out_value;
        logic               status;
    } t_out_beat;

    typedef struct packed {
        t_in_beat req;
        logic     is_alu;
        logic     is_load;
        logic     is_store;
        logic     is_out;
        logic     base_a;
        logic     base_b;
        logic     use_off;
    } t_dec;

    typedef struct packed {
        logic valid;
        t_dec item;
    } t_q_head;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_q_ctl;

endpackage

@@ rtl/iloc_ram.sv @@
module iloc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/iloc_front.sv @@
module iloc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  iloc_pkg::t_in_beat i_in_data,
    output logic              o_in_stall,
    input  iloc_pkg::t_q_ctl  i_ctl,
    output iloc_pkg::t_q_head o_head
);

    iloc_pkg::t_dec dec;
    iloc_pkg::t_dec r_slot [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic [1:0]     n_cnt;
    logic           push;

    always_comb begin
        dec          = '0;
        dec.req      = i_in_data;
        case (i_in_data.req_type) inside
            [iloc_pkg::OP_ADD:iloc_pkg::OP_LOADI]: dec.is_alu = 1'b1;
            iloc_pkg::OP_LOAD: begin
                dec.is_load = 1'b1;
                dec.base_a  = 1'b1;
            end
            iloc_pkg::OP_LOADAI: begin
                dec.is_load = 1'b1;
                dec.base_a  = 1'b1;
                dec.use_off = 1'b1;
            end
            iloc_pkg::OP_STORE: begin
                dec.is_store = 1'b1;
                dec.base_b   = 1'b1;
            end
            iloc_pkg::OP_STOREAI: begin
                dec.is_store = 1'b1;
                dec.base_b   = 1'b1;
                dec.use_off  = 1'b1;
            end
            iloc_pkg::OP_OUT_IMM: begin
                dec.is_out  = 1'b1;
                dec.use_off = 1'b1;
            end
            iloc_pkg::OP_OUT_AI: begin
                dec.is_out  = 1'b1;
                dec.base_a  = 1'b1;
                dec.use_off = 1'b1;
            end
            default: dec = dec;
        endcase
    end

    assign o_in_stall = (r_cnt == 2'd2) || i_ctl.clearing;
    assign push       = i_in_valid && !o_in_stall;
    assign n_cnt      = r_cnt + {1'b0, push} - {1'b0, i_ctl.pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= !r_wp;
            end
            if (i_ctl.pop) begin
                r_rp <= !r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= dec;
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_slot[r_rp];

endmodule

@@ rtl/iloc_back.sv @@
module iloc_back #(
    parameter int NUM_REGS  = 64,
    parameter int MEM_WORDS = 32768
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  iloc_pkg::t_q_head  i_head,
    output iloc_pkg::t_q_ctl   o_ctl,
    output logic               o_out_valid,
    output iloc_pkg::t_out_beat o_out_data,
    input  logic               i_out_stall
);

    localparam int RAW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int MAW = $clog2(MEM_WORDS);

    typedef enum logic [2:0] {
        S_CLR = 3'b001,
        S_RD  = 3'b010,
        S_EX  = 3'b100
    } t_bk_state;

    t_bk_state      r_state;
    t_bk_state      n_state;
    logic [MAW-1:0] r_clr_idx;
    iloc_pkg::t_dec r_ex;
    logic           pop;
    logic           credit;

    // forward copy of the latest register write
    logic           r_fwd_valid;
    logic [5:0]     r_fwd_idx;
    logic [31:0]    r_fwd_data;

    // writeback stage
    logic           r_w_valid;
    logic           r_w_wr;
    logic           r_w_from_mem;
    logic [5:0]     r_w_dest;
    logic [31:0]    r_w_alu;
    logic           r_w_has;
    logic           r_w_status;

    // result queue
    iloc_pkg::t_out_beat r_oq [2];
    logic           r_oq_wp;
    logic           r_oq_rp;
    logic [1:0]     r_oq_cnt;
    logic           oq_pop;
    iloc_pkg::t_out_beat res;

    logic [31:0]    ram_a;
    logic [31:0]    ram_b;
    logic [31:0]    dm_rdata;
    logic           rf_we;
    logic [RAW-1:0] rf_waddr;
    logic [31:0]    rf_wdata;
    logic           dm_we;
    logic [MAW-1:0] dm_waddr;
    logic [31:0]    dm_wdata;
    logic           dm_re;

    logic           a_ok;
    logic           b_ok;
    logic [31:0]    va;
    logic [31:0]    vb;
    logic [31:0]    imm32;
    logic [31:0]    base;
    logic [33:0]    sum;
    logic           addr_ok;
    logic [31:0]    mul_b;
    logic [31:0]    prod;
    logic [31:0]    alu;
    logic [4:0]     sh;
    logic           clearing;
    logic           in_ex;

    assign clearing = (r_state == S_CLR);
    assign in_ex    = (r_state == S_EX);
    assign credit   = (r_oq_cnt == 2'd0) || ((r_oq_cnt == 2'd1) && !r_w_valid);

    always_comb begin
        n_state = r_state;
        pop     = 1'b0;
        case (r_state)
            S_CLR: begin
                if (r_clr_idx == MAW'(MEM_WORDS - 1)) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (i_head.valid && credit) begin
                    pop     = 1'b1;
                    n_state = S_EX;
                end
            end
            S_EX: n_state = S_RD;
            default: n_state = S_CLR;
        endcase
    end

    assign o_ctl.pop      = pop;
    assign o_ctl.clearing = clearing;

    // execute
    assign a_ok  = 32'(r_ex.req.src_a_reg) < 32'(NUM_REGS);
    assign b_ok  = 32'(r_ex.req.src_b_reg) < 32'(NUM_REGS);
    assign va    = !a_ok ? 32'd0 :
                   (r_fwd_valid && r_fwd_idx == r_ex.req.src_a_reg) ? r_fwd_data : ram_a;
    assign vb    = !b_ok ? 32'd0 :
                   (r_fwd_valid && r_fwd_idx == r_ex.req.src_b_reg) ? r_fwd_data : ram_b;
    assign imm32 = {1'b0, r_ex.req.imm_value};
    assign base  = r_ex.base_a ? va : (r_ex.base_b ? vb : 32'd0);
    assign sum   = {{2{base[31]}}, base} + (r_ex.use_off ? {3'b000, r_ex.req.imm_value} : 34'd0);
    assign addr_ok = !sum[33] && (sum < 34'(MEM_WORDS));
    assign sh    = vb[4:0];
    assign mul_b = (r_ex.req.req_type == iloc_pkg::OP_MULTI) ? imm32 : vb;
    assign prod  = va * mul_b;

    always_comb begin
        case (r_ex.req.req_type)
            iloc_pkg::OP_ADD:    alu = va + vb;
            iloc_pkg::OP_SUB:    alu = va - vb;
            iloc_pkg::OP_ADDI:   alu = va + imm32;
            iloc_pkg::OP_SUBI:   alu = va - imm32;
            iloc_pkg::OP_MUL,
            iloc_pkg::OP_MULTI:  alu = prod;
            iloc_pkg::OP_LSHIFT: alu = va << sh;
            iloc_pkg::OP_RSHIFT: alu = 32'($signed(va) >>> sh);
            iloc_pkg::OP_LOADI:  alu = imm32;
            default:             alu = 32'd0;
        endcase
    end

    // memories
    assign rf_we    = clearing ? (32'(r_clr_idx) < 32'(NUM_REGS)) : (r_w_valid && r_w_wr);
    assign rf_waddr = clearing ? RAW'(r_clr_idx) : RAW'(r_w_dest);
    assign rf_wdata = clearing ? 32'd0 : (r_w_from_mem ? dm_rdata : r_w_alu);

    assign dm_we    = clearing || (in_ex && r_ex.is_store && addr_ok);
    assign dm_waddr = clearing ? r_clr_idx : sum[MAW-1:0];
    assign dm_wdata = clearing ? 32'd0 : va;
    assign dm_re    = in_ex && (r_ex.is_load || r_ex.is_out) && addr_ok;

    iloc_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_re    (r_state == S_RD),
        .i_raddr (RAW'(i_head.item.req.src_a_reg)),
        .o_rdata (ram_a)
    );

    iloc_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_re    (r_state == S_RD),
        .i_raddr (RAW'(i_head.item.req.src_b_reg)),
        .o_rdata (ram_b)
    );

    iloc_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (dm_we),
        .i_waddr (dm_waddr),
        .i_wdata (dm_wdata),
        .i_re    (dm_re),
        .i_raddr (sum[MAW-1:0]),
        .o_rdata (dm_rdata)
    );

    // result of the writeback stage
    assign res.has_output = r_w_has;
    assign res.out_value  = r_w_has ? dm_rdata : 32'sd0;
    assign res.status     = r_w_status;

    assign o_out_valid = (r_oq_cnt != 2'd0);
    assign o_out_data  = r_oq[r_oq_rp];
    assign oq_pop      = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_idx   <= '0;
            r_w_valid   <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_oq_wp     <= 1'b0;
            r_oq_rp     <= 1'b0;
            r_oq_cnt    <= 2'd0;
        end else begin
            r_state <= n_state;
            if (clearing) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            r_w_valid <= in_ex;
            if (r_w_valid && r_w_wr) begin
                r_fwd_valid <= 1'b1;
            end
            r_oq_cnt <= r_oq_cnt + {1'b0, r_w_valid} - {1'b0, oq_pop};
            if (r_w_valid) begin
                r_oq_wp <= !r_oq_wp;
            end
            if (oq_pop) begin
                r_oq_rp <= !r_oq_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_ex <= i_head.item;
        end
        if (in_ex) begin
            r_w_wr       <= (r_ex.is_alu || (r_ex.is_load && addr_ok))
                            && (32'(r_ex.req.dest_reg) < 32'(NUM_REGS));
            r_w_from_mem <= r_ex.is_load;
            r_w_dest     <= r_ex.req.dest_reg;
            r_w_alu      <= alu;
            r_w_has      <= r_ex.is_out && addr_ok;
            r_w_status   <= (r_ex.is_load || r_ex.is_store || r_ex.is_out) && !addr_ok;
        end
        if (r_w_valid && r_w_wr) begin
            r_fwd_idx  <= r_w_dest;
            r_fwd_data <= rf_wdata;
        end
        if (r_w_valid) begin
            r_oq[r_oq_wp] <= res;
        end
    end

endmodule

@@ rtl/iloc_instruction_executor.sv @@
// ILOC instruction executor: one decoded instruction per input beat, one
// result beat per instruction, in order.
// Input channel: i_in_valid / o_in_stall carry i_in_data (opcode, register
// indexes, immediate). A beat is taken on a clock edge with valid high and
// stall low. A two-entry queue decouples the decoder from the execute side.
// Output channel: o_out_valid / i_out_stall carry o_out_data (has_output,
// out_value, status) from a two-entry result queue.
// Path from input beat to result beat: input queue, register file read,
// execute, writeback, result queue. A new instruction is issued only once
// the previous one has passed its register file read and its execute step
// (address add, multiply or memory access); the register write of one
// instruction overlaps the read of the next and is forwarded.
// Reset: after i_rst_n the block zeroes the data memory and register file in
// a pass of MEM_WORDS cycles, holding o_in_stall high meanwhile.
// When the receiver stalls, results collect in the result queue; execution
// pauses once it cannot hold another result, and then the input queue
// fills and o_in_stall rises.
`include "iloc_instruction_executor_macros.svh"

module iloc_instruction_executor #(
    parameter int NUM_REGS  = 64,
    parameter int MEM_WORDS = 32768
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  iloc_pkg::t_in_beat  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output iloc_pkg::t_out_beat o_out_data,
    input  logic                i_out_stall
);

    iloc_pkg::t_q_head head;
    iloc_pkg::t_q_ctl  ctl;

    iloc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_ctl      (ctl),
        .o_head     (head)
    );

    iloc_back #(.NUM_REGS(NUM_REGS), .MEM_WORDS(MEM_WORDS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_ctl       (ctl),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    `ILOC_ASSERT(a_pop_has_item, ctl.pop |-> head.valid, "pop from empty queue")
    `ILOC_ASSERT_NEXT(a_pop_spacing, ctl.pop, !ctl.pop, "two issues in adjacent cycles")
    `ILOC_ASSERT(a_clear_stalls, ctl.clearing |-> o_in_stall, "input taken during clear")
    `ILOC_ASSERT(a_clear_no_issue, ctl.clearing |-> !ctl.pop, "issue during clear")

endmodule
